/* design/rotation_matrix_to_quaternion_unit_assert.svh */
// assertion macros shared by the checker of the quaternion unit
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/rmq_pkg.sv */
// shared constants and types of the rotation matrix to quaternion unit
package rmq_pkg;

	localparam int FRAC_BITS  = 30;
	localparam int DATA_W     = 32;
	localparam int NUM_W      = 34;
	localparam int RAD_W      = 64;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = DATA_W;
	localparam int DIV_LAT    = DIV_STEPS + 2;
	localparam int PIPE_LAT   = 1 + SQRT_STEPS + DIV_LAT + 1;

	typedef enum logic [1:0] {
		PART_W = 2'd0,
		PART_X = 2'd1,
		PART_Y = 2'd2,
		PART_Z = 2'd3
	} part_t;

	// payload that rides along the square root pipe
	typedef struct packed {
		part_t                    part;
		logic signed [NUM_W-1:0]  num_a;
		logic signed [NUM_W-1:0]  num_b;
		logic signed [NUM_W-1:0]  num_c;
	} sq_side_t;

	// what the final select needs besides the divider lanes
	typedef struct packed {
		part_t             part;
		logic [DATA_W-1:0] root;
	} tail_t;

	// flags carried through a divider lane
	typedef struct packed {
		logic neg;
		logic num_zero;
		logic root_zero;
		logic ovf;
	} div_flags_t;

endpackage

/* design/rmq_ifs.sv */
// matrix input and quaternion output channel interfaces
interface rmq_mat_if;
	import rmq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] elem_00;
	logic signed [DATA_W-1:0] elem_01;
	logic signed [DATA_W-1:0] elem_02;
	logic signed [DATA_W-1:0] elem_10;
	logic signed [DATA_W-1:0] elem_11;
	logic signed [DATA_W-1:0] elem_12;
	logic signed [DATA_W-1:0] elem_20;
	logic signed [DATA_W-1:0] elem_21;
	logic signed [DATA_W-1:0] elem_22;

	modport source (output valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
		elem_20, elem_21, elem_22, input ready);
	modport sink (input valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
		elem_20, elem_21, elem_22, output ready);
endinterface

interface rmq_quat_if;
	import rmq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] quat_x;
	logic signed [DATA_W-1:0] quat_y;
	logic signed [DATA_W-1:0] quat_z;
	logic signed [DATA_W-1:0] quat_w;
	logic [1:0]               dominant_part;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, dominant_part,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, dominant_part,
		output ready);
endinterface

/* design/rmq_front.sv */
// branch select, radicand and off-diagonal numerators, one register stage
module rmq_front (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rmq_pkg::DATA_W-1:0] m00,
	input  logic signed [rmq_pkg::DATA_W-1:0] m01,
	input  logic signed [rmq_pkg::DATA_W-1:0] m02,
	input  logic signed [rmq_pkg::DATA_W-1:0] m10,
	input  logic signed [rmq_pkg::DATA_W-1:0] m11,
	input  logic signed [rmq_pkg::DATA_W-1:0] m12,
	input  logic signed [rmq_pkg::DATA_W-1:0] m20,
	input  logic signed [rmq_pkg::DATA_W-1:0] m21,
	input  logic signed [rmq_pkg::DATA_W-1:0] m22,
	output logic [rmq_pkg::RAD_W-1:0]         rad_s1,
	output rmq_pkg::sq_side_t                 side_s1
);
	import rmq_pkg::*;

	localparam int ARG_W = DATA_W + 3;
	localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) <<< FRAC_BITS;

	logic signed [ARG_W-1:0] e00, e11, e22, trace, arg;
	logic signed [NUM_W-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
	logic [RAD_W-1:0]        rad;
	sq_side_t                side;

	always_comb begin
		e00    = ARG_W'(m00);
		e11    = ARG_W'(m11);
		e22    = ARG_W'(m22);
		trace  = e00 + e11 + e22;
		d21_12 = NUM_W'(m21) - NUM_W'(m12);
		d02_20 = NUM_W'(m02) - NUM_W'(m20);
		d10_01 = NUM_W'(m10) - NUM_W'(m01);
		s01_10 = NUM_W'(m01) + NUM_W'(m10);
		s02_20 = NUM_W'(m02) + NUM_W'(m20);
		s12_21 = NUM_W'(m12) + NUM_W'(m21);
		if (trace > 0) begin
			side.part  = PART_W;
			arg        = trace + ONE;
			side.num_a = d21_12;
			side.num_b = d02_20;
			side.num_c = d10_01;
		end else if (m00 > m11 && m00 > m22) begin
			side.part  = PART_X;
			arg        = ONE + e00 - e11 - e22;
			side.num_a = s01_10;
			side.num_b = s02_20;
			side.num_c = d21_12;
		end else if (m11 > m22) begin
			side.part  = PART_Y;
			arg        = ONE + e11 - e00 - e22;
			side.num_a = s01_10;
			side.num_b = s12_21;
			side.num_c = d02_20;
		end else begin
			side.part  = PART_Z;
			arg        = ONE + e22 - e00 - e11;
			side.num_a = s02_20;
			side.num_b = s12_21;
			side.num_c = d10_01;
		end
		// negative argument clamps to zero
		if (arg < 0) begin
			rad = '0;
		end else begin
			rad = RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= rad;
			side_s1 <= side;
		end
	end

endmodule

/* design/rmq_sqrt.sv */
// integer square root, one result bit per pipeline stage
module rmq_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rmq_pkg::RAD_W-1:0]  rad,
	input  rmq_pkg::sq_side_t          side_in,
	output logic [rmq_pkg::DATA_W-1:0] root,
	output rmq_pkg::sq_side_t          side_out
);
	import rmq_pkg::*;

	logic [RAD_W-1:0] n_s   [0:SQRT_STEPS];
	logic [RAD_W-1:0] res_s [0:SQRT_STEPS];
	sq_side_t         side_s [0:SQRT_STEPS];

	assign n_s[0]    = rad;
	assign res_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
		logic [RAD_W-1:0] trial;
		assign trial = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (n_s[k] >= trial) begin
					n_s[k+1]   <= n_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1]   <= n_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign root     = res_s[SQRT_STEPS][DATA_W-1:0];
	assign side_out = side_s[SQRT_STEPS];

endmodule

/* design/rmq_div_lane.sv */
// signed num / (2 root) in fixed point, rounded and saturated, restoring pipeline
module rmq_div_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rmq_pkg::NUM_W-1:0]  num,
	input  logic [rmq_pkg::DATA_W-1:0]        root,
	output logic signed [rmq_pkg::DATA_W-1:0] quot
);
	import rmq_pkg::*;

	localparam int NW = NUM_W + FRAC_BITS;
	localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic [NUM_W-1:0]  mag;
	logic [NW-1:0]     dividend;
	logic [DATA_W:0]   divisor;
	logic [DATA_W-1:0] hi;
	div_flags_t        flg;

	logic [DATA_W:0]   rem_s  [0:DIV_STEPS];
	logic [DATA_W-1:0] nlo_s  [0:DIV_STEPS];
	logic [DATA_W-1:0] q_s    [0:DIV_STEPS];
	logic [DATA_W:0]   dv_s   [0:DIV_STEPS];
	div_flags_t        flg_s  [0:DIV_STEPS];

	// prep: magnitude, rounding term, overflow check
	always_comb begin
		flg.neg       = num[NUM_W-1];
		flg.num_zero  = (num == '0);
		flg.root_zero = (root == '0);
		mag           = flg.neg ? NUM_W'(-num) : NUM_W'(num);
		dividend      = (NW'(mag) << FRAC_BITS) + NW'(root);
		divisor       = {root, 1'b0};
		hi            = dividend[NW-1:DATA_W];
		flg.ovf       = ({1'b0, hi} >= divisor);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, hi};
			nlo_s[0] <= dividend[DATA_W-1:0];
			q_s[0]   <= '0;
			dv_s[0]  <= divisor;
			flg_s[0] <= flg;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DATA_W+1:0] t;
		logic [DATA_W+1:0] dz;
		assign t  = {rem_s[k], nlo_s[k][DATA_W-1]};
		assign dz = {1'b0, dv_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				nlo_s[k+1] <= nlo_s[k] << 1;
				dv_s[k+1]  <= dv_s[k];
				flg_s[k+1] <= flg_s[k];
				if (t >= dz) begin
					rem_s[k+1] <= (DATA_W+1)'(t - dz);
					q_s[k+1]   <= {q_s[k][DATA_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= t[DATA_W:0];
					q_s[k+1]   <= {q_s[k][DATA_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (flg_s[DIV_STEPS].root_zero) begin
				quot <= flg_s[DIV_STEPS].num_zero ? '0 :
					(flg_s[DIV_STEPS].neg ? S_MIN : S_MAX);
			end else if (flg_s[DIV_STEPS].ovf || q_s[DIV_STEPS][DATA_W-1]) begin
				quot <= flg_s[DIV_STEPS].neg ? S_MIN : S_MAX;
			end else if (flg_s[DIV_STEPS].neg) begin
				quot <= -$signed(q_s[DIV_STEPS]);
			end else begin
				quot <= $signed(q_s[DIV_STEPS]);
			end
		end
	end

endmodule

/* design/rotation_matrix_to_quaternion_unit.sv */
// top level: rotation matrix to quaternion, largest-term branch method, fully pipelined
//
// Converts a 3x3 rotation matrix (nine signed Q2.30 elements) into the quaternion
// x, y, z, w in Q2.30 plus the branch taken (0 w, 1 x, 2 y, 3 z first). One matrix
// beat is accepted every clock cycle while the output is not stalled; each result
// passes a branch select and radicand register, 32 square root stages (one root
// bit each), three parallel restoring dividers (prep, 32 quotient bits, round and
// saturate) and one output register. The whole pipe advances together: when a
// result waits at the output and is not taken, in_mat.ready drops and everything
// holds; otherwise a new beat may enter each cycle. A negative root argument is
// clamped to zero and a zero divisor saturates by numerator sign.
module rotation_matrix_to_quaternion_unit (
	input  logic         clk,
	input  logic         arst_n,
	rmq_mat_if.sink      in_mat,
	rmq_quat_if.source   out_quat
);
	import rmq_pkg::*;

	// global advance: pipe moves unless the output beat is stuck
	logic en;
	logic vld_s [0:PIPE_LAT-1];

	logic [RAD_W-1:0]  rad_s1;
	sq_side_t          side_s1;
	logic [DATA_W-1:0] root;
	sq_side_t          side_sq;
	logic signed [DATA_W-1:0] qa, qb, qc;
	tail_t             tail_s [0:DIV_LAT];

	logic signed [DATA_W-1:0] dom;
	logic signed [DATA_W-1:0] ox, oy, oz, ow;
	logic signed [DATA_W-1:0] qx_q, qy_q, qz_q, qw_q;
	part_t                    part_q;

	assign en           = !vld_s[PIPE_LAT-1] || out_quat.ready;
	assign in_mat.ready = en;

	// valid bits travel beside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_mat.valid;
			for (int i = 1; i < PIPE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	rmq_front u_front (
		.clk     (clk),
		.en      (en),
		.m00     (in_mat.elem_00),
		.m01     (in_mat.elem_01),
		.m02     (in_mat.elem_02),
		.m10     (in_mat.elem_10),
		.m11     (in_mat.elem_11),
		.m12     (in_mat.elem_12),
		.m20     (in_mat.elem_20),
		.m21     (in_mat.elem_21),
		.m22     (in_mat.elem_22),
		.rad_s1  (rad_s1),
		.side_s1 (side_s1)
	);

	rmq_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.rad      (rad_s1),
		.side_in  (side_s1),
		.root     (root),
		.side_out (side_sq)
	);

	// three dividers for the non-dominant components
	rmq_div_lane u_div_a (.clk(clk), .en(en), .num(side_sq.num_a), .root(root), .quot(qa));
	rmq_div_lane u_div_b (.clk(clk), .en(en), .num(side_sq.num_b), .root(root), .quot(qb));
	rmq_div_lane u_div_c (.clk(clk), .en(en), .num(side_sq.num_c), .root(root), .quot(qc));

	// branch and root delayed to match the divider latency
	assign tail_s[0].part = side_sq.part;
	assign tail_s[0].root = root;

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_tail
		always_ff @(posedge clk) begin
			if (en) begin
				tail_s[k+1] <= tail_s[k];
			end
		end
	end

	// dominant component is root / 2, always in range
	always_comb begin
		dom = $signed(tail_s[DIV_LAT].root >> 1);
		unique case (tail_s[DIV_LAT].part)
			PART_W: begin
				ox = qa; oy = qb; oz = qc; ow = dom;
			end
			PART_X: begin
				ox = dom; oy = qa; oz = qb; ow = qc;
			end
			PART_Y: begin
				ox = qa; oy = dom; oz = qb; ow = qc;
			end
			default: begin
				ox = qa; oy = qb; oz = dom; ow = qc;
			end
		endcase
	end

	// output register holds the beat until taken
	always_ff @(posedge clk) begin
		if (en) begin
			qx_q   <= ox;
			qy_q   <= oy;
			qz_q   <= oz;
			qw_q   <= ow;
			part_q <= tail_s[DIV_LAT].part;
		end
	end

	assign out_quat.valid         = vld_s[PIPE_LAT-1];
	assign out_quat.quat_x        = qx_q;
	assign out_quat.quat_y        = qy_q;
	assign out_quat.quat_z        = qz_q;
	assign out_quat.quat_w        = qw_q;
	assign out_quat.dominant_part = part_q;

endmodule

/* design/rmq_checker.sv */
// port-level checker for the quaternion unit and its bind
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [rmq_pkg::DATA_W-1:0] quat_x,
	input logic signed [rmq_pkg::DATA_W-1:0] quat_y,
	input logic signed [rmq_pkg::DATA_W-1:0] quat_z,
	input logic signed [rmq_pkg::DATA_W-1:0] quat_w,
	input logic [1:0]                       dominant_part
);
	import rmq_pkg::*;

	// stuck output beat stalls the input side
	`RMQ_ASSERT_IMP(a_stall_in, clk, arst_n, out_valid && !out_ready, !in_ready)

	// a pending beat stays put
	`RMQ_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(quat_x) && $stable(quat_w) && $stable(dominant_part))

	// the component computed first is half a root and never negative
	`RMQ_ASSERT_IMP(a_dom_pos, clk, arst_n, out_valid, !((dominant_part == PART_W && quat_w[DATA_W-1]) || (dominant_part == PART_X && quat_x[DATA_W-1]) || (dominant_part == PART_Y && quat_y[DATA_W-1]) || (dominant_part == PART_Z && quat_z[DATA_W-1])))

	// free output side means the input is open
	`RMQ_ASSERT_IMP(a_open, clk, arst_n, !out_valid || out_ready, in_ready)

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_mat.ready),
	.out_valid     (out_quat.valid),
	.out_ready     (out_quat.ready),
	.quat_x        (out_quat.quat_x),
	.quat_y        (out_quat.quat_y),
	.quat_z        (out_quat.quat_z),
	.quat_w        (out_quat.quat_w),
	.dominant_part (out_quat.dominant_part)
);

/* dv/rmq_quat_checker.sv */
// checker: watches both channels, predicts each quaternion and compares
module rmq_quat_checker
	import rmq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	rmq_mat_if    mat,
	rmq_quat_if   quat,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		part_t              part;
	} quat_t;

	quat_t expected_quats[$];

	assign pending = expected_quats.size();

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// rounded num / (2r), saturated by numerator sign when r is zero
	function automatic logic signed [31:0] scaled_div(input longint num, input logic [63:0] r);
		logic [63:0] mag;
		logic [63:0] q;
		if (r == 0) begin
			if (num > 0)
				return 32'h7fffffff;
			if (num < 0)
				return 32'h80000000;
			return 0;
		end
		mag = num < 0 ? -num : num;
		q = ((mag << FRAC_BITS) + r) / (r << 1);
		if (q > (64'd1 << 32))
			q = 64'd1 << 32;
		return clamp32(num < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic quat_t predict_quat(input longint m00, m01, m02, m10, m11, m12,
		m20, m21, m22);
		longint one;
		longint tr;
		longint arg;
		logic [63:0] r;
		logic signed [31:0] half;
		quat_t q;
		one = longint'(1) << FRAC_BITS;
		tr = m00 + m11 + m22;
		if (tr > 0) begin
			q.part = PART_W;
			arg = tr + one;
		end else if (m00 > m11 && m00 > m22) begin
			q.part = PART_X;
			arg = one + m00 - m11 - m22;
		end else if (m11 > m22) begin
			q.part = PART_Y;
			arg = one + m11 - m00 - m22;
		end else begin
			q.part = PART_Z;
			arg = one + m22 - m00 - m11;
		end
		if (arg < 0)
			arg = 0;
		r = int_sqrt(64'(arg) << FRAC_BITS);
		half = clamp32(longint'(r >> 1));
		case (q.part)
			PART_W: begin
				q.x = scaled_div(m21 - m12, r);
				q.y = scaled_div(m02 - m20, r);
				q.z = scaled_div(m10 - m01, r);
				q.w = half;
			end
			PART_X: begin
				q.x = half;
				q.y = scaled_div(m01 + m10, r);
				q.z = scaled_div(m02 + m20, r);
				q.w = scaled_div(m21 - m12, r);
			end
			PART_Y: begin
				q.x = scaled_div(m01 + m10, r);
				q.y = half;
				q.z = scaled_div(m12 + m21, r);
				q.w = scaled_div(m02 - m20, r);
			end
			default: begin
				q.x = scaled_div(m02 + m20, r);
				q.y = scaled_div(m12 + m21, r);
				q.z = half;
				q.w = scaled_div(m10 - m01, r);
			end
		endcase
		return q;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quat_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (mat.valid && mat.ready)
				expected_quats.push_back(predict_quat(mat.elem_00, mat.elem_01, mat.elem_02,
					mat.elem_10, mat.elem_11, mat.elem_12, mat.elem_20, mat.elem_21,
					mat.elem_22));
			if (quat.valid && quat.ready) begin
				if (expected_quats.size() == 0) begin
					$error("quaternion beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_quats.pop_front();
					if (quat.quat_x !== e.x || quat.quat_y !== e.y || quat.quat_z !== e.z ||
						quat.quat_w !== e.w || quat.dominant_part !== e.part)
						fail_count <= fail_count + 1;
					if (quat.quat_x !== e.x)
						$error("quat_x expected %0d got %0d", e.x, quat.quat_x);
					if (quat.quat_y !== e.y)
						$error("quat_y expected %0d got %0d", e.y, quat.quat_y);
					if (quat.quat_z !== e.z)
						$error("quat_z expected %0d got %0d", e.z, quat.quat_z);
					if (quat.quat_w !== e.w)
						$error("quat_w expected %0d got %0d", e.w, quat.quat_w);
					if (quat.dominant_part !== e.part)
						$error("dominant_part expected %0d got %0d", e.part,
							quat.dominant_part);
				end
			end
		end
	end

endmodule

/* dv/tb.sv */
// testbench top: matrix stimulus, output stalls and the verdict
module tb;
	import rmq_pkg::*;

	localparam int ONE = 1 << FRAC_BITS;
	localparam int N_RANDOM = 930;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   hold_output;   // long receiver hold-off while the sender keeps going

	rmq_mat_if  mat ();
	rmq_quat_if quat ();

	rotation_matrix_to_quaternion_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_mat   (mat.sink),
		.out_quat (quat.source)
	);

	rmq_quat_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat        (mat),
		.quat       (quat),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

	// drive one matrix beat and hold it until it is taken
	task automatic send_matrix(input logic [31:0] e[9]);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			mat.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mat.valid   <= 1'b1;
		mat.elem_00 <= e[0];
		mat.elem_01 <= e[1];
		mat.elem_02 <= e[2];
		mat.elem_10 <= e[3];
		mat.elem_11 <= e[4];
		mat.elem_12 <= e[5];
		mat.elem_20 <= e[6];
		mat.elem_21 <= e[7];
		mat.elem_22 <= e[8];
		@(posedge clk);
		while (!mat.ready)
			@(posedge clk);
	endtask

	// random element: mostly near unit range, sometimes any 32-bit value, an extreme or zero
	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 0;
			default: return $signed($urandom_range(0, 32'h7fffffff)) - ONE;
		endcase
	endfunction

	// mostly a well-formed rotation built from random signs and permutation, perturbed; else nine random elements
	task automatic make_matrix(output logic [31:0] e[9]);
		int perm;
		int k;
		int jitter;
		if ($urandom_range(0, 3) == 0) begin
			for (k = 0; k < 9; k++)
				e[k] = rand_elem();
		end else begin
			perm = $urandom_range(0, 2);
			for (k = 0; k < 9; k++)
				e[k] = $signed($urandom_range(0, ONE / 2)) - ONE / 4;
			for (k = 0; k < 3; k++) begin
				jitter = $urandom_range(0, ONE / 4);
				e[k * 3 + (k + perm) % 3] = $urandom_range(0, 1) ? ONE - jitter : jitter - ONE;
			end
		end
	endtask

	// receiver: random per-beat stalls, or a long hold when asked
	initial begin
		int wait_cycles;
		quat.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				quat.ready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_output = 0;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (wait_cycles > 0) begin
				quat.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			quat.ready <= 1'b1;
			@(posedge clk);
			while (!quat.valid)
				@(posedge clk);
		end
	end

	initial begin
		logic [31:0] e[9];
		int n;
		int k;
		int limit;
		hold_output = 0;
		arst_n      = 0;
		mat.valid   <= 1'b0;
		mat.elem_00 <= 0;
		mat.elem_01 <= 0;
		mat.elem_02 <= 0;
		mat.elem_10 <= 0;
		mat.elem_11 <= 0;
		mat.elem_12 <= 0;
		mat.elem_20 <= 0;
		mat.elem_21 <= 0;
		mat.elem_22 <= 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity: w branch
		e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		send_matrix(e);
		// 180 deg about x, y, z: each non-w branch
		e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
		send_matrix(e);
		e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};
		send_matrix(e);
		e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};
		send_matrix(e);
		// equal diagonal ties fall to later branches
		e = '{-ONE/2, 5, 7, 9, -ONE/2, 11, 13, 17, -ONE/2};
		send_matrix(e);
		e = '{-ONE/4, 1, 2, 3, -ONE/2, 4, 5, 6, -ONE/2};
		send_matrix(e);
		e = '{-ONE/2, 1, 2, 3, -ONE/4, 4, 5, 6, -ONE/4};
		send_matrix(e);
		// tied negative diagonals take the z branch, with zero and negative numerators
		e = '{-ONE, 100, -ONE, 50, -ONE, 0, ONE, 0, -ONE};
		send_matrix(e);
		e = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		send_matrix(e);
		// extreme and small values, overflow and saturation
		e = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
		send_matrix(e);
		e = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
		send_matrix(e);
		e = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
		send_matrix(e);
		e = '{0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 0};
		send_matrix(e);
		// trace of exactly zero is not positive
		e = '{ONE, 3, 4, 5, -ONE, 6, 7, 8, 0};
		send_matrix(e);

		for (n = 0; n < N_RANDOM; n++) begin
			// long output hold while the input keeps being offered
			if (n == 200)
				hold_output = 1;
			// sender pause until the pipe drains
			if (n == 500) begin
				mat.valid <= 1'b0;
				@(posedge clk);
				limit = 0;
				while (pending != 0 && limit < 20000) begin
					@(posedge clk);
					limit++;
				end
			end
			make_matrix(e);
			send_matrix(e);
		end
		mat.valid <= 1'b0;

		limit = 0;
		while (pending != 0 && limit < 50000) begin
			@(posedge clk);
			limit++;
		end
		repeat (80) @(posedge clk);
		if (pending == 0 && fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
